// ===== rtl/iee_pkg.sv =====
// Package for the infix expression evaluator: data width, character codes,
// micro-op and sequencing codes, control structs and the microprogram table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package iee_pkg;

    // Arithmetic width; results wrap at this many bits.
    localparam int DATA_WIDTH = 32;
    localparam int DIV_CNT_W  = $clog2(DATA_WIDTH);
    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 32;
    localparam int UADDR_W    = 4;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [UADDR_W-1:0]    t_uaddr;

    // Character codes of interest.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Operator waiting for its right-hand number.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_MUL  = 2'd1;
    localparam logic [1:0] PEND_DIV  = 2'd2;

    // Character classes used by the dispatch step.
    localparam logic [1:0] CLS_OTHER  = 2'd0;
    localparam logic [1:0] CLS_DIGIT  = 2'd1;
    localparam logic [1:0] CLS_MULDIV = 2'd2;
    localparam logic [1:0] CLS_ADDSUB = 2'd3;

    // Sequencing field of a control word.
    localparam logic [2:0] SEQ_NEXT     = 3'd0;
    localparam logic [2:0] SEQ_JUMP     = 3'd1;
    localparam logic [2:0] SEQ_WAIT_IN  = 3'd2;
    localparam logic [2:0] SEQ_DISPATCH = 3'd3;
    localparam logic [2:0] SEQ_IF_DIV   = 3'd4;
    localparam logic [2:0] SEQ_WAIT_DIV = 3'd5;
    localparam logic [2:0] SEQ_IF_LAST  = 3'd6;
    localparam logic [2:0] SEQ_WAIT_OUT = 3'd7;

    // Datapath micro-operations.
    localparam logic [2:0] UOP_NOP       = 3'd0;
    localparam logic [2:0] UOP_LOAD      = 3'd1;
    localparam logic [2:0] UOP_DIGIT     = 3'd2;
    localparam logic [2:0] UOP_FIN_START = 3'd3;
    localparam logic [2:0] UOP_FIN_DIV   = 3'd4;
    localparam logic [2:0] UOP_SET_OP    = 3'd5;
    localparam logic [2:0] UOP_SIGN      = 3'd6;
    localparam logic [2:0] UOP_EMIT      = 3'd7;

    // Microprogram addresses.
    localparam t_uaddr A_FETCH    = 4'd0;
    localparam t_uaddr A_DISPATCH = 4'd1;
    localparam t_uaddr A_DIGIT    = 4'd2;
    localparam t_uaddr A_MD_FIN   = 4'd3;
    localparam t_uaddr A_MD_WAIT  = 4'd4;
    localparam t_uaddr A_MD_SET   = 4'd5;
    localparam t_uaddr A_AS_FIN   = 4'd6;
    localparam t_uaddr A_AS_WAIT  = 4'd7;
    localparam t_uaddr A_AS_SIGN  = 4'd8;
    localparam t_uaddr A_CHK_LAST = 4'd9;
    localparam t_uaddr A_END_FIN  = 4'd10;
    localparam t_uaddr A_END_WAIT = 4'd11;
    localparam t_uaddr A_EMIT     = 4'd12;

    typedef struct packed {
        logic [2:0] seq;
        logic [2:0] uop;
        t_uaddr     target;
    } t_uword;

    // Sequencer to datapath: operation of this step and whether it takes effect.
    typedef struct packed {
        logic [2:0] uop;
        logic       fire;
    } t_seq_ctl;

    // Datapath to sequencer: conditions for jumps and waits.
    typedef struct packed {
        logic [1:0] cls;
        logic       last;
        logic       div_go;
        logic       div_done;
        logic       out_full;
    } t_dp_flags;

    // The microprogram.
    function automatic t_uword ucode_rom(input t_uaddr addr);
        t_uword w;
        w = '{seq: SEQ_JUMP, uop: UOP_NOP, target: A_FETCH};
        case (addr)
            A_FETCH:    w = '{seq: SEQ_WAIT_IN,  uop: UOP_LOAD,      target: A_FETCH};
            A_DISPATCH: w = '{seq: SEQ_DISPATCH, uop: UOP_NOP,       target: A_FETCH};
            A_DIGIT:    w = '{seq: SEQ_JUMP,     uop: UOP_DIGIT,     target: A_CHK_LAST};
            A_MD_FIN:   w = '{seq: SEQ_IF_DIV,   uop: UOP_FIN_START, target: A_MD_SET};
            A_MD_WAIT:  w = '{seq: SEQ_WAIT_DIV, uop: UOP_FIN_DIV,   target: A_FETCH};
            A_MD_SET:   w = '{seq: SEQ_JUMP,     uop: UOP_SET_OP,    target: A_CHK_LAST};
            A_AS_FIN:   w = '{seq: SEQ_IF_DIV,   uop: UOP_FIN_START, target: A_AS_SIGN};
            A_AS_WAIT:  w = '{seq: SEQ_WAIT_DIV, uop: UOP_FIN_DIV,   target: A_FETCH};
            A_AS_SIGN:  w = '{seq: SEQ_NEXT,     uop: UOP_SIGN,      target: A_FETCH};
            A_CHK_LAST: w = '{seq: SEQ_IF_LAST,  uop: UOP_NOP,       target: A_FETCH};
            A_END_FIN:  w = '{seq: SEQ_IF_DIV,   uop: UOP_FIN_START, target: A_EMIT};
            A_END_WAIT: w = '{seq: SEQ_WAIT_DIV, uop: UOP_FIN_DIV,   target: A_FETCH};
            A_EMIT:     w = '{seq: SEQ_WAIT_OUT, uop: UOP_EMIT,      target: A_FETCH};
            default:    w = '{seq: SEQ_JUMP,     uop: UOP_NOP,       target: A_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/iee_in_if.sv =====
// Character channel of the expression evaluator: valid/ready plus one word.
// Depends on iee_pkg for the character width.
`default_nettype none

interface iee_in_if import iee_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/iee_out_if.sv =====
// Result channel of the expression evaluator: valid/ready plus one word.
// Depends on iee_pkg for the value width.
`default_nettype none

interface iee_out_if import iee_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      div_zero;

    modport source (output valid, output value, output div_zero, input ready);
    modport sink   (input valid, input value, input div_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/iee_divider.sv =====
// Signed truncating divider, restoring, one quotient bit per cycle.
// Depends on iee_pkg for the data width.
`default_nettype none

module iee_divider import iee_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_data i_dividend,
    input  wire t_data i_divisor,
    output logic       o_done,
    output t_data      o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic                 r_neg, n_neg;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    t_data                r_rem, n_rem;
    t_data                r_quo, n_quo;
    t_data                r_den, n_den;
    logic [DATA_WIDTH:0]  shifted;
    logic [DATA_WIDTH:0]  diff;

    // One restoring step: shift in the next dividend bit, try the subtraction.
    always_comb begin
        shifted = {r_rem, r_quo[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, r_den};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_neg  = i_dividend[DATA_WIDTH-1] ^ i_divisor[DATA_WIDTH-1];
            n_quo  = i_dividend[DATA_WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_den  = i_divisor[DATA_WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_rem  = '0;
            n_cnt  = DIV_CNT_W'(DATA_WIDTH - 1);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (!diff[DATA_WIDTH]) begin
                n_rem = diff[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = shifted[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    // The magnitude quotient takes the sign of the operands at the end.
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

// ===== rtl/iee_datapath.sv =====
// Datapath of the expression evaluator: number, term, sum and flag registers
// driven by micro-ops, the output register, and the divider.
// Depends on iee_pkg and iee_divider.
`default_nettype none

module iee_datapath import iee_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_seq_ctl          i_ctl,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_last,
    input  wire logic              i_out_ready,
    output t_dp_flags              o_flags,
    output logic                   o_out_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                   o_div_zero
);

    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    t_data              r_acc, n_acc;
    logic               r_have, n_have;
    t_data              r_term, n_term;
    logic [1:0]         r_pend, n_pend;
    t_data              r_sum, n_sum;
    logic               r_neg, n_neg;
    logic               r_err, n_err;
    logic               r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic               r_div_zero, n_div_zero;

    logic               is_digit;
    logic [1:0]         cls;
    logic               div_go;
    logic               div_start;
    logic               div_done;
    t_data              quotient;
    t_data              signed_term;
    t_data              final_sum;
    t_data              product;
    t_data              acc_next;
    logic               fire;

    iee_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_term),
        .i_divisor  (r_acc),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Character class of the latched word.
    always_comb begin
        is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
        if (is_digit) begin
            cls = CLS_DIGIT;
        end else if (r_char == CH_STAR || r_char == CH_SLASH) begin
            cls = CLS_MULDIV;
        end else if (r_char == CH_PLUS || r_char == CH_MINUS) begin
            cls = CLS_ADDSUB;
        end else begin
            cls = CLS_OTHER;
        end
    end

    // A finished number meets a waiting divide by a non-zero divisor.
    assign div_go    = r_have && (r_pend == PEND_DIV) && (r_acc != '0);
    assign fire      = i_ctl.fire;
    assign div_start = fire && (i_ctl.uop == UOP_FIN_START) && div_go;

    // Arithmetic for the micro-ops.
    always_comb begin
        product     = DATA_WIDTH'(r_term * r_acc);
        acc_next    = (r_acc << 3) + (r_acc << 1) + DATA_WIDTH'(r_char[3:0]);
        signed_term = r_neg ? (~r_term + 1'b1) : r_term;
        final_sum   = r_sum + signed_term;
    end

    always_comb begin
        n_acc       = r_acc;
        n_have      = r_have;
        n_term      = r_term;
        n_pend      = r_pend;
        n_sum       = r_sum;
        n_neg       = r_neg;
        n_err       = r_err;
        n_value     = r_value;
        n_div_zero  = r_div_zero;
        n_out_valid = r_out_valid && !i_out_ready;
        if (fire) begin
            unique case (i_ctl.uop)
                UOP_DIGIT: begin
                    n_acc  = acc_next;
                    n_have = 1'b1;
                end
                UOP_FIN_START: begin
                    if (r_have && !div_go) begin
                        priority if (r_pend == PEND_MUL) begin
                            n_term = product;
                        end else if (r_pend == PEND_DIV) begin
                            n_err  = 1'b1;
                            n_term = '0;
                        end else begin
                            n_term = r_acc;
                        end
                        n_pend = PEND_NONE;
                        n_have = 1'b0;
                        n_acc  = '0;
                    end
                end
                UOP_FIN_DIV: begin
                    n_term = quotient;
                    n_pend = PEND_NONE;
                    n_have = 1'b0;
                    n_acc  = '0;
                end
                UOP_SET_OP: begin
                    n_pend = (r_char == CH_STAR) ? PEND_MUL : PEND_DIV;
                end
                UOP_SIGN: begin
                    if (r_pend == PEND_NONE) begin
                        n_sum  = final_sum;
                        n_term = '0;
                    end
                    n_neg = (r_char == CH_MINUS);
                end
                UOP_EMIT: begin
                    n_value     = VALUE_W'($signed(final_sum));
                    n_div_zero  = r_err;
                    n_out_valid = 1'b1;
                    n_acc       = '0;
                    n_have      = 1'b0;
                    n_term      = '0;
                    n_pend      = PEND_NONE;
                    n_sum       = '0;
                    n_neg       = 1'b0;
                    n_err       = 1'b0;
                end
                UOP_LOAD, UOP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_have      <= 1'b0;
            r_term      <= '0;
            r_pend      <= PEND_NONE;
            r_sum       <= '0;
            r_neg       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_have      <= n_have;
            r_term      <= n_term;
            r_pend      <= n_pend;
            r_sum       <= n_sum;
            r_neg       <= n_neg;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_value    <= n_value;
        r_div_zero <= n_div_zero;
    end

    // Latch the incoming word when the fetch step takes it.
    always_ff @(posedge i_clk) begin
        if (fire && i_ctl.uop == UOP_LOAD) begin
            r_char <= i_char_code;
            r_last <= i_last;
        end
    end

    always_comb begin
        o_flags.cls      = cls;
        o_flags.last     = r_last;
        o_flags.div_go   = div_go;
        o_flags.div_done = div_done;
        o_flags.out_full = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_div_zero  = r_div_zero;

endmodule

`default_nettype wire

// ===== rtl/iee_sequencer.sv =====
// Microprogram sequencer: step counter, control word table and jump logic.
// Depends on iee_pkg for the microprogram and control structs.
`default_nettype none

module iee_sequencer import iee_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_dp_flags i_flags,
    output logic           o_in_ready,
    output t_seq_ctl       o_ctl
);

    t_uaddr r_upc, n_upc;
    t_uword uw;
    logic   fire;

    assign uw = ucode_rom(r_upc);

    // Pick the next step and decide whether the current one takes effect.
    always_comb begin
        fire  = 1'b1;
        n_upc = r_upc + 1'b1;
        unique case (uw.seq)
            SEQ_NEXT: begin
                n_upc = r_upc + 1'b1;
            end
            SEQ_JUMP: begin
                n_upc = uw.target;
            end
            SEQ_WAIT_IN: begin
                fire  = i_in_valid;
                n_upc = fire ? r_upc + 1'b1 : r_upc;
            end
            SEQ_DISPATCH: begin
                unique case (i_flags.cls)
                    CLS_DIGIT:  n_upc = A_DIGIT;
                    CLS_MULDIV: n_upc = A_MD_FIN;
                    CLS_ADDSUB: n_upc = A_AS_FIN;
                    default:    n_upc = A_CHK_LAST;
                endcase
            end
            SEQ_IF_DIV: begin
                n_upc = i_flags.div_go ? r_upc + 1'b1 : uw.target;
            end
            SEQ_WAIT_DIV: begin
                fire  = i_flags.div_done;
                n_upc = fire ? r_upc + 1'b1 : r_upc;
            end
            SEQ_IF_LAST: begin
                n_upc = i_flags.last ? r_upc + 1'b1 : uw.target;
            end
            SEQ_WAIT_OUT: begin
                fire  = !i_flags.out_full;
                n_upc = fire ? uw.target : r_upc;
            end
            default: begin
                n_upc = A_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_in_ready = (uw.seq == SEQ_WAIT_IN);
    assign o_ctl.uop  = uw.uop;
    assign o_ctl.fire = fire;

endmodule

`default_nettype wire

// ===== rtl/infix_expression_evaluator.sv =====
// Top level of the infix integer expression evaluator.
// Depends on iee_pkg, iee_in_if, iee_out_if, iee_sequencer and iee_datapath.
//
// Usage: i_char carries one ASCII character per word with a last flag;
// o_result carries one word per expression: the signed sum and a sticky
// division-by-zero flag. Both channels move a word when valid and ready are
// high at a rising edge of i_clk.
// Steps: each character passes fetch and dispatch, then the digit step for a
// digit, finish and set for '*' or '/', finish and sign for '+' or '-', and
// last the last-check step. A finished number that meets a waiting '/' runs
// the bit-serial divider, which holds the sequencer until it is done. The
// last character then passes finish (and the divider when a '/' waits) and
// emit, which loads the result into the output register that drives o_result.
// Rate is set by the microprogram, one control step per cycle while no step
// waits, and by the one-bit-per-cycle divider.
// Reset (i_rst_n low, synchronous) returns the step counter to the fetch
// step and clears the number, term, sum and flags, and the output valid flag.
// A stalled receiver holds the result; the block keeps taking characters of
// the next expression and only waits at its final step if the previous
// result has still not been taken.
`default_nettype none

module infix_expression_evaluator import iee_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iee_in_if.sink    i_char,
    iee_out_if.source o_result
);

    t_seq_ctl  ctl;
    t_dp_flags flags;
    logic      in_ready;

    iee_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .i_flags    (flags),
        .o_in_ready (in_ready),
        .o_ctl      (ctl)
    );

    iee_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_char_code (i_char.char_code),
        .i_last      (i_char.last),
        .i_out_ready (o_result.ready),
        .o_flags     (flags),
        .o_out_valid (o_result.valid),
        .o_value     (o_result.value),
        .o_div_zero  (o_result.div_zero)
    );

    assign i_char.ready = in_ready;

endmodule

`default_nettype wire

// ===== bench/tb_infix_expression_evaluator.sv =====
// Testbench for the infix expression evaluator: sends expressions one character
// word at a time and checks each result against a predictor held here or a typed one.
// Depends on iee_pkg, iee_in_if, iee_out_if and infix_expression_evaluator.

module tb_infix_expression_evaluator;
    import iee_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PRINT_CAP    = 100;

    // Characters the stimulus needs beyond those of the package.
    localparam byte unsigned CH_SPACE    = 8'h20;
    localparam byte unsigned CH_NUL      = 8'h00;
    localparam byte unsigned CH_NUL_MARK = 8'h23;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct {
        t_value value;
        logic   div_zero;
    } t_sum_word;

    typedef struct {
        string  text;
        bit     typed;
        t_value value;
        logic   div_zero;
    } t_directed_row;

    // Directed expressions. A '#' stands for the NUL code, which a string
    // cannot hold. Results are typed in only where they are plain to see.
    t_directed_row directed_rows [5] = '{
        '{"#7\377",                 1'b1, 32'sd7,          1'b0},
        '{"9/0",                    1'b1, 32'sd0,          1'b1},
        '{"2147483648/12884901887", 1'b1, 32'sh8000_0000,  1'b0},
        '{"+-5*/+2*",               1'b0, 32'sd0,          1'b0},
        '{"*3+4-1",                 1'b0, 32'sd0,          1'b0}
    };

    logic clk;
    logic rst_n;

    iee_in_if  char_if ();
    iee_out_if res_if ();

    infix_expression_evaluator u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_char   (char_if),
        .o_result (res_if)
    );

    // Predictor state, one copy of what the evaluator holds.
    t_data      num_acc;
    bit         num_open;
    t_data      term_acc;
    logic [1:0] waiting_op;
    t_data      sum_acc;
    bit         term_minus;
    bit         zero_div_seen;

    t_sum_word    expected_sums [$];
    byte unsigned expr_text [$];

    bit steady;
    int cycle_cnt      = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int chars_sent     = 0;
    int directed_chars = 0;
    int drain_pauses   = 0;

    // Clock, period 2.
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        end
    endtask

    // Truncating signed division at the data width.
    function automatic t_data trunc_quotient(t_data a, t_data b);
        t_data mag_a;
        t_data mag_b;
        t_data quot;
        mag_a = a[DATA_WIDTH-1] ? -a : a;
        mag_b = b[DATA_WIDTH-1] ? -b : b;
        quot  = mag_a / mag_b;
        return (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? -quot : quot;
    endfunction

    function automatic void clear_evaluator();
        num_acc       = '0;
        num_open      = 1'b0;
        term_acc      = '0;
        waiting_op    = PEND_NONE;
        sum_acc       = '0;
        term_minus    = 1'b0;
        zero_div_seen = 1'b0;
    endfunction

    // Fold a finished number into the term, by the operator waiting for it.
    function automatic void settle_number();
        if (!num_open) begin
            return;
        end
        case (waiting_op)
            PEND_MUL: begin
                term_acc = term_acc * num_acc;
            end
            PEND_DIV: begin
                if (num_acc == '0) begin
                    zero_div_seen = 1'b1;
                    term_acc      = '0;
                end else begin
                    term_acc = trunc_quotient(term_acc, num_acc);
                end
            end
            default: begin
                term_acc = num_acc;
            end
        endcase
        waiting_op = PEND_NONE;
        num_open   = 1'b0;
        num_acc    = '0;
    endfunction

    function automatic void close_term();
        sum_acc  = sum_acc + (term_minus ? -term_acc : term_acc);
        term_acc = '0;
    endfunction

    // Takes one character; returns 1 with the sum when the expression ends.
    function automatic bit eval_char(byte unsigned c, bit is_last, output t_sum_word word);
        logic signed [DATA_WIDTH-1:0] signed_sum;
        word.value    = '0;
        word.div_zero = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            num_acc  = num_acc * 10 + t_data'(c - CH_ZERO);
            num_open = 1'b1;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            settle_number();
            waiting_op = (c == CH_STAR) ? PEND_MUL : PEND_DIV;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            settle_number();
            if (waiting_op == PEND_NONE) begin
                close_term();
            end
            term_minus = (c == CH_MINUS);
        end
        if (!is_last) begin
            return 1'b0;
        end
        settle_number();
        waiting_op = PEND_NONE;
        close_term();
        signed_sum    = sum_acc;
        word.value    = VALUE_W'(signed_sum);
        word.div_zero = zero_div_seen;
        clear_evaluator();
        return 1'b1;
    endfunction

    // Idle cycles before a word: mostly none or a few, now and then many.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Send one character word and book its expected sum, if it ends an expression.
    task automatic send_char(byte unsigned c, bit is_last, bit typed, t_sum_word typed_word);
        int        gap;
        t_sum_word word;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            char_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.last      <= is_last;
        do @(posedge clk); while (char_if.ready !== 1'b1);
        chars_sent++;
        if (eval_char(c, is_last, word)) begin
            expected_sums.push_back(typed ? typed_word : word);
        end
    endtask

    // Numbers: mostly short, some long enough to wrap, a few at the extremes.
    function automatic void add_number();
        int    r;
        int    n_digits;
        string fixed;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            case ($urandom_range(0, 2))
                0:       fixed = "4294967295";
                1:       fixed = "2147483648";
                default: fixed = "12884901887";
            endcase
            for (int i = 0; i < fixed.len(); i++) begin
                expr_text.push_back(fixed[i]);
            end
            return;
        end
        n_digits = (r < 60) ? $urandom_range(1, 2) :
                   (r < 88) ? $urandom_range(3, 5) : $urandom_range(9, 12);
        for (int i = 0; i < n_digits; i++) begin
            expr_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            r = $urandom_range(0, 39);
            if (r == 0) begin
                expr_text.push_back(CH_SPACE);
            end else if (r == 1) begin
                expr_text.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    function automatic void add_operator(byte unsigned op);
        if ($urandom_range(0, 9) == 0) begin
            expr_text.push_back(CH_SPACE);
        end
        expr_text.push_back(op);
    endfunction

    // Mostly well-formed sums of products; the rest are loose operator and
    // digit runs with stray characters.
    function automatic void build_expression();
        int n_terms;
        int n_factors;
        int n_chars;
        expr_text.delete();
        if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 4) == 0) begin
                add_operator($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            end
            n_terms = $urandom_range(1, 4);
            for (int t = 0; t < n_terms; t++) begin
                if (t > 0) begin
                    add_operator($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                end
                n_factors = $urandom_range(1, 3);
                for (int f = 0; f < n_factors; f++) begin
                    if (f > 0) begin
                        add_operator($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
                    end
                    add_number();
                end
            end
        end else begin
            n_chars = $urandom_range(1, 8);
            for (int i = 0; i < n_chars; i++) begin
                case ($urandom_range(0, 5))
                    0, 1:    expr_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    2:       expr_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    3:       expr_text.push_back($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
                    4:       expr_text.push_back(CH_SPACE);
                    default: expr_text.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endfunction

    // Result side: ready in runs, with short and occasional long stalls.
    initial begin : result_sink
        int hold;
        int r;
        bit rdy;
        hold = 0;
        rdy  = 1'b0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (steady || r < 60) begin
                    rdy  = 1'b1;
                    hold = $urandom_range(1, 8);
                end else if (r < 92) begin
                    rdy  = 1'b0;
                    hold = $urandom_range(1, 3);
                end else begin
                    rdy  = 1'b0;
                    hold = $urandom_range(10, 50);
                end
            end
            hold--;
            res_if.ready <= rdy;
        end
    end

    // Compare each accepted result word with the oldest expected sum.
    always @(posedge clk) begin : result_check
        t_sum_word word;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            results_seen++;
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("result %0d with no expression outstanding",
                                          res_if.value));
            end else begin
                word = expected_sums.pop_front();
                if (res_if.value !== word.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              res_if.value, word.value));
                end
                if (res_if.div_zero !== word.div_zero) begin
                    report_mismatch($sformatf("div_zero %b, expected %b",
                                              res_if.div_zero, word.div_zero));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d sums still expected",
                     cycle_cnt, expected_sums.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        t_sum_word    typed_word;
        byte unsigned c;
        int           expr_count;
        int           n_len;
        expr_count        = 0;
        steady            = 1'b0;
        rst_n             = 1'b0;
        char_if.valid     = 1'b0;
        char_if.char_code = '0;
        char_if.last      = 1'b0;
        clear_evaluator();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed expressions.
        foreach (directed_rows[r]) begin
            typed_word.value    = directed_rows[r].value;
            typed_word.div_zero = directed_rows[r].div_zero;
            n_len = directed_rows[r].text.len();
            for (int i = 0; i < n_len; i++) begin
                c = directed_rows[r].text[i];
                if (c == CH_NUL_MARK) begin
                    c = CH_NUL;
                end
                send_char(c, i == n_len - 1, directed_rows[r].typed, typed_word);
            end
        end
        directed_chars = chars_sent;

        // Random expressions, with stretches of no idling and drain pauses.
        while (chars_sent < RANDOM_ITEMS) begin
            if (expr_count % 25 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            if (expr_count % 40 == 20) begin
                @(negedge clk);
                char_if.valid <= 1'b0;
                while (expected_sums.size() != 0) @(posedge clk);
                drain_pauses++;
            end
            build_expression();
            foreach (expr_text[i]) begin
                send_char(expr_text[i], i == expr_text.size() - 1, 1'b0, typed_word);
            end
            expr_count++;
        end
        @(negedge clk);
        char_if.valid <= 1'b0;

        while (expected_sums.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d character words (%0d directed) in %0d random expressions,",
                 chars_sent, directed_chars, expr_count);
        $display("%0d result words checked, %0d drain pauses, %0d mismatches.",
                 results_seen, drain_pauses, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iee_pkg.sv
rtl/iee_in_if.sv
rtl/iee_out_if.sv
rtl/iee_divider.sv
rtl/iee_datapath.sv
rtl/iee_sequencer.sv
rtl/infix_expression_evaluator.sv
bench/tb_infix_expression_evaluator.sv
